[sv/descriptor_slot_allocator_top_macros.svh]
// assertion macros for the descriptor slot allocator
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define DSA_ASSERT_IMPL(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error(msg);

// next-cycle implication
`define DSA_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error(msg);

`endif

[sv/dsa_pkg.sv]
// shared types and constants of the descriptor slot allocator
`timescale 1ns / 1ps

package dsa_pkg;

  localparam int MAX_SLOTS_DEF = 1024;
  localparam int CAP_W         = 11;
  localparam int STRIDE_W      = 13;
  localparam int ADDR_W        = 48;
  localparam int SLOT_OUT_W    = 10;
  localparam int PROD_W        = SLOT_OUT_W + STRIDE_W;
  localparam int CFG_IDX_W     = 2;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RESERVE = 2'd1,
    CMD_FREE    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_REJECT   = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY = 2'd0,
    REG_STRIDE   = 2'd1,
    REG_CPU_BASE = 2'd2,
    REG_GPU_BASE = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_PUSH = 3'd1,
    CELL_POP  = 3'd2,
    CELL_LOAD = 3'd3,
    CELL_ROT  = 3'd4,
    CELL_SWAP = 3'd5
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     phase;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    OCC_HOLD  = 2'd0,
    OCC_CLR   = 2'd1,
    OCC_CNT   = 2'd2,
    OCC_SHIFT = 2'd3
  } occ_op_e;

  typedef struct packed {
    occ_op_e op;
    logic    bc_valid;
  } occ_ctrl_t;

endpackage

[sv/dsa_stack_cell.sv]
// one entry of the free stack chain, top of stack at index zero
`timescale 1ns / 1ps

module dsa_stack_cell import dsa_pkg::*; #(
  parameter int SLOT_W = 10,
  parameter int IDX    = 0
) (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [SLOT_W-1:0] up_val_i,
  input  logic              up_hole_i,
  input  logic [SLOT_W-1:0] dn_val_i,
  input  logic              dn_hole_i,
  output logic [SLOT_W-1:0] val_o,
  output logic              hole_o
);

  localparam logic [SLOT_W-1:0] LoadVal = SLOT_W'(IDX);
  localparam logic              Parity  = 1'(IDX % 2);

  logic [SLOT_W-1:0] val_q, val_d;
  logic              hole_q, hole_d;

  always_comb begin
    val_d  = val_q;
    hole_d = hole_q;
    case (ctrl_i.op)
      CELL_PUSH: begin
        val_d  = up_val_i;
        hole_d = up_hole_i;
      end
      CELL_POP, CELL_ROT: begin
        val_d  = dn_val_i;
        hole_d = dn_hole_i;
      end
      CELL_LOAD: begin
        val_d  = LoadVal;
        hole_d = 1'b0;
      end
      CELL_SWAP: begin
        // lower cell of the pair takes from below, upper from above
        if (Parity == ctrl_i.phase) begin
          if (hole_q && !dn_hole_i) begin
            val_d  = dn_val_i;
            hole_d = dn_hole_i;
          end
        end else if (up_hole_i && !hole_q) begin
          val_d  = up_val_i;
          hole_d = up_hole_i;
        end
      end
      default: begin
        val_d  = val_q;
        hole_d = hole_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    hole_q <= hole_d;
  end

  assign val_o  = val_q;
  assign hole_o = hole_q;

endmodule

[sv/dsa_occ_cell.sv]
// saturating occurrence counter for one slot value
`timescale 1ns / 1ps

module dsa_occ_cell import dsa_pkg::*; #(
  parameter int SLOT_W = 10,
  parameter int IDX    = 0
) (
  input  logic              clk_i,
  input  occ_ctrl_t         ctrl_i,
  input  logic [SLOT_W-1:0] bc_val_i,
  input  logic [1:0]        dn_occ_i,
  output logic [1:0]        occ_o
);

  localparam logic [SLOT_W-1:0] MyVal = SLOT_W'(IDX);

  logic [1:0] occ_q, occ_d;

  always_comb begin
    occ_d = occ_q;
    case (ctrl_i.op)
      OCC_CLR:   occ_d = 2'd0;
      OCC_CNT: begin
        if (ctrl_i.bc_valid && bc_val_i == MyVal && occ_q != 2'd2) begin
          occ_d = occ_q + 2'd1;
        end
      end
      OCC_SHIFT: occ_d = dn_occ_i;
      default:   occ_d = occ_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    occ_q <= occ_d;
  end

  assign occ_o = occ_q;

endmodule

[sv/dsa_div.sv]
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module dsa_div import dsa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [ADDR_W-1:0]   dividend_i,
  input  logic [STRIDE_W-1:0] divisor_i,
  output logic                done_o,
  output logic [ADDR_W-1:0]   quotient_o
);

  localparam int StepW = $clog2(ADDR_W);
  localparam logic [StepW-1:0] LastStep = StepW'(ADDR_W - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [StepW-1:0]    step_q, step_d;
  logic [ADDR_W-1:0]   quo_q, quo_d;
  logic [STRIDE_W-1:0] rem_q, rem_d;
  logic [STRIDE_W-1:0] dsr_q, dsr_d;
  logic [STRIDE_W:0]   shifted;
  logic                ge;

  always_comb begin
    shifted = {rem_q, quo_q[ADDR_W-1]};
    ge      = shifted >= {1'b0, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[ADDR_W-2:0], ge};
      rem_d = ge ? STRIDE_W'(shifted - {1'b0, dsr_q}) : shifted[STRIDE_W-1:0];
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[sv/descriptor_slot_allocator_top.sv]
// top level of the descriptor slot allocator
`timescale 1ns / 1ps
// usage:
// one command word enters on in_valid_i/in_stall_o and one result word
// leaves on out_valid_o/out_stall_i; a word moves when valid is high and
// stall is low. configuration is written on cfg_we_i/cfg_idx_i/cfg_wdata_i
// while the block is idle; a capacity write refills the free stack at once.
// one command is worked at a time; in_stall_o is high until its result
// sits in the output register.
// rejects and cmd 3 go straight to the output register; alloc passes
// through multiply and add, free through the bit serial divider, and
// reserve through count and scan passes and, on a grant, mark and
// compaction passes, then multiply and add. the next command is taken in
// the cycle after its result is loaded. a stalled result stays in the
// output register; the next command is taken but its result waits until
// the register frees. reset empties the stack, clears the control and
// configuration registers and makes the heap inactive.

`include "descriptor_slot_allocator_top_macros.svh"

module descriptor_slot_allocator_top import dsa_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            cmd_i,
  input  logic [CAP_W-1:0]      count_i,
  input  logic [ADDR_W-1:0]     cpu_handle_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [SLOT_OUT_W-1:0] slot_index_o,
  output logic [ADDR_W-1:0]     cpu_address_o,
  output logic [ADDR_W-1:0]     gpu_address_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ADDR_W-1:0]     cfg_wdata_i
);

  localparam int SlotW = $clog2(MAX_SLOTS);
  localparam int CntW  = $clog2(MAX_SLOTS + 1);
  localparam int CmpW  = (CntW > CAP_W) ? CntW : CAP_W;
  localparam logic [CntW-1:0] LastPos = CntW'(MAX_SLOTS - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_OCC  = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_MARK = 4'd3;
  localparam logic [3:0] S_SWAP = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_ADD  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]            state_q, state_d;
  logic [CntW-1:0]       capacity_q, capacity_d;
  logic [STRIDE_W-1:0]   stride_q, stride_d;
  logic [ADDR_W-1:0]     cpu_base_q, cpu_base_d;
  logic [ADDR_W-1:0]     gpu_base_q, gpu_base_d;
  logic [CntW-1:0]       stack_cnt_q, stack_cnt_d;
  logic [CntW-1:0]       pos_q, pos_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [SlotW-1:0]      run_start_q, run_start_d;
  logic [CntW-1:0]       run_len_q, run_len_d;
  logic [CntW-1:0]       removed_q, removed_d;
  logic                  phase_q, phase_d;
  logic [1:0]            res_status_q, res_status_d;
  logic [SLOT_OUT_W-1:0] res_slot_q, res_slot_d;
  logic                  res_grant_q, res_grant_d;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [ADDR_W-1:0]     res_cpu_q, res_cpu_d;
  logic [ADDR_W-1:0]     res_gpu_q, res_gpu_d;
  logic                  out_valid_q, out_valid_d;
  logic [1:0]            out_status_q;
  logic [SLOT_OUT_W-1:0] out_slot_q;
  logic [ADDR_W-1:0]     out_cpu_q, out_gpu_q;
  logic                  out_load;

  cell_ctrl_t            cell_ctrl;
  occ_ctrl_t             occ_ctrl;
  logic [SlotW-1:0]      cval [MAX_SLOTS];
  logic                  chole [MAX_SLOTS];
  logic [1:0]            occv [MAX_SLOTS];
  logic [SlotW-1:0]      fb_val;
  logic                  fb_hole;
  logic [SlotW-1:0]      push_val;
  logic                  mark_hit;

  logic                  div_start, div_done;
  logic [ADDR_W-1:0]     div_quo;

  logic                  accept;
  logic [CAP_W-1:0]      cap_wr;
  logic [CntW-1:0]       cap_sat;
  logic [CntW-1:0]       ext;
  logic [SlotW-1:0]      start_p;
  logic [SlotW-1:0]      scan_v;
  logic [CntW:0]         run_end;

  assign accept     = (state_q == S_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign cap_wr     = cfg_wdata_i[CAP_W-1:0];
  assign cap_sat    = (CmpW'(cap_wr) > CmpW'(MAX_SLOTS)) ? CntW'(MAX_SLOTS) : CntW'(cap_wr);
  assign push_val   = SlotW'(div_quo);
  assign fb_val     = cval[0];
  assign scan_v     = SlotW'(pos_q);
  assign ext        = (run_len_q != '0) ? run_len_q + 1'b1 : CntW'(1);
  assign start_p    = (run_len_q != '0) ? run_start_q : scan_v;
  assign run_end    = (CntW + 1)'(run_start_q) + (CntW + 1)'(cnt_q);
  assign mark_hit   = (pos_q < stack_cnt_q) && (cval[0] >= run_start_q) &&
                      ((CntW + 1)'(cval[0]) < run_end);
  assign fb_hole    = (state_q == S_MARK) ? mark_hit :
                      (state_q == S_SWAP) ? 1'b1 : chole[0];
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cells
    logic [SlotW-1:0] up_val, dn_val;
    logic             up_hole, dn_hole;
    logic [1:0]       dn_occ;
    if (i == 0) begin : g_first
      assign up_val  = push_val;
      assign up_hole = 1'b0;
    end else begin : g_mid_up
      assign up_val  = cval[i-1];
      assign up_hole = chole[i-1];
    end
    if (i == MAX_SLOTS - 1) begin : g_last
      assign dn_val  = fb_val;
      assign dn_hole = fb_hole;
      assign dn_occ  = 2'd0;
    end else begin : g_mid_dn
      assign dn_val  = cval[i+1];
      assign dn_hole = chole[i+1];
      assign dn_occ  = occv[i+1];
    end

    dsa_stack_cell #(
      .SLOT_W (SlotW),
      .IDX    (i)
    ) u_stack_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl),
      .up_val_i  (up_val),
      .up_hole_i (up_hole),
      .dn_val_i  (dn_val),
      .dn_hole_i (dn_hole),
      .val_o     (cval[i]),
      .hole_o    (chole[i])
    );

    dsa_occ_cell #(
      .SLOT_W (SlotW),
      .IDX    (i)
    ) u_occ_cell (
      .clk_i    (clk_i),
      .ctrl_i   (occ_ctrl),
      .bc_val_i (cval[0]),
      .dn_occ_i (dn_occ),
      .occ_o    (occv[i])
    );
  end

  dsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cpu_handle_i - cpu_base_q),
    .divisor_i  (stride_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d      = state_q;
    capacity_d   = capacity_q;
    stride_d     = stride_q;
    cpu_base_d   = cpu_base_q;
    gpu_base_d   = gpu_base_q;
    stack_cnt_d  = stack_cnt_q;
    pos_d        = pos_q;
    cnt_d        = cnt_q;
    run_start_d  = run_start_q;
    run_len_d    = run_len_q;
    removed_d    = removed_q;
    phase_d      = phase_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_grant_d  = res_grant_q;
    prod_d       = prod_q;
    res_cpu_d    = res_cpu_q;
    res_gpu_d    = res_gpu_q;
    cell_ctrl    = '{op: CELL_HOLD, phase: phase_q};
    occ_ctrl     = '{op: OCC_HOLD, bc_valid: 1'b0};
    div_start    = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CAPACITY: begin
          capacity_d    = cap_sat;
          stack_cnt_d   = cap_sat;
          cell_ctrl.op  = CELL_LOAD;
        end
        REG_STRIDE:   stride_d   = cfg_wdata_i[STRIDE_W-1:0];
        REG_CPU_BASE: cpu_base_d = cfg_wdata_i;
        REG_GPU_BASE: gpu_base_d = cfg_wdata_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = ST_OK;
          res_slot_d   = '0;
          res_grant_d  = 1'b0;
          state_d      = S_OUT;
          unique case (cmd_e'(cmd_i))
            CMD_ALLOC: begin
              if (stack_cnt_q == '0) begin
                res_status_d = ST_NO_SPACE;
              end else begin
                res_slot_d   = SLOT_OUT_W'(cval[0]);
                res_grant_d  = 1'b1;
                stack_cnt_d  = stack_cnt_q - 1'b1;
                cell_ctrl.op = CELL_POP;
                state_d      = S_MUL;
              end
            end
            CMD_RESERVE: begin
              if (count_i == '0 || CmpW'(count_i) > CmpW'(capacity_q) ||
                  CmpW'(count_i) > CmpW'(stack_cnt_q)) begin
                res_status_d = ST_NO_SPACE;
              end else begin
                cnt_d       = CntW'(count_i);
                occ_ctrl.op = OCC_CLR;
                pos_d       = '0;
                state_d     = S_OCC;
              end
            end
            CMD_FREE: begin
              if (capacity_q == '0 || stride_q == '0 || cpu_handle_i < cpu_base_q) begin
                res_status_d = ST_REJECT;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      S_OCC: begin
        cell_ctrl.op      = CELL_ROT;
        occ_ctrl.op       = OCC_CNT;
        occ_ctrl.bc_valid = pos_q < stack_cnt_q;
        if (pos_q == LastPos) begin
          pos_d     = '0;
          run_len_d = '0;
          state_d   = S_SCAN;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      S_SCAN: begin
        occ_ctrl.op = OCC_SHIFT;
        pos_d       = pos_q + 1'b1;
        if (occv[0] == 2'd0) begin
          run_len_d = '0;
        end else if (ext == cnt_q) begin
          run_start_d = start_p;
          pos_d       = '0;
          removed_d   = '0;
          state_d     = S_MARK;
        end else if (occv[0][1]) begin
          run_start_d = scan_v;
          run_len_d   = CntW'(1);
        end else begin
          run_start_d = start_p;
          run_len_d   = ext;
        end
        if (state_d == S_SCAN && pos_q == LastPos) begin
          res_status_d = ST_NO_SPACE;
          state_d      = S_OUT;
        end
      end
      S_MARK: begin
        cell_ctrl.op = CELL_ROT;
        if (mark_hit) begin
          removed_d = removed_q + 1'b1;
        end
        if (pos_q == LastPos) begin
          pos_d   = '0;
          phase_d = 1'b0;
          state_d = S_SWAP;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      S_SWAP: begin
        cell_ctrl.op = CELL_SWAP;
        phase_d      = !phase_q;
        if (pos_q == LastPos) begin
          stack_cnt_d  = stack_cnt_q - removed_q;
          res_status_d = ST_OK;
          res_slot_d   = SLOT_OUT_W'(run_start_q);
          res_grant_d  = 1'b1;
          state_d      = S_MUL;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
          if (div_quo >= ADDR_W'(capacity_q)) begin
            res_status_d = ST_REJECT;
          end else if (stack_cnt_q >= capacity_q) begin
            res_status_d = ST_FULL;
            res_slot_d   = SLOT_OUT_W'(div_quo);
          end else begin
            res_status_d = ST_OK;
            res_slot_d   = SLOT_OUT_W'(div_quo);
            cell_ctrl.op = CELL_PUSH;
            stack_cnt_d  = stack_cnt_q + 1'b1;
          end
        end
      end
      S_MUL: begin
        prod_d  = PROD_W'(res_slot_q) * PROD_W'(stride_q);
        state_d = S_ADD;
      end
      S_ADD: begin
        res_cpu_d = cpu_base_q + ADDR_W'(prod_q);
        res_gpu_d = gpu_base_q + ADDR_W'(prod_q);
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      capacity_q  <= '0;
      stride_q    <= '0;
      cpu_base_q  <= '0;
      gpu_base_q  <= '0;
      stack_cnt_q <= '0;
      pos_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      capacity_q  <= capacity_d;
      stride_q    <= stride_d;
      cpu_base_q  <= cpu_base_d;
      gpu_base_q  <= gpu_base_d;
      stack_cnt_q <= stack_cnt_d;
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    run_start_q  <= run_start_d;
    run_len_q    <= run_len_d;
    removed_q    <= removed_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_grant_q  <= res_grant_d;
    prod_q       <= prod_d;
    res_cpu_q    <= res_cpu_d;
    res_gpu_q    <= res_gpu_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_cpu_q    <= res_grant_q ? res_cpu_q : '0;
      out_gpu_q    <= res_grant_q ? res_gpu_q : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign slot_index_o  = out_slot_q;
  assign cpu_address_o = out_cpu_q;
  assign gpu_address_o = out_gpu_q;

  `DSA_ASSERT_IMPL(a_cnt_le_cap, 1'b1, stack_cnt_q <= capacity_q,
                   "free stack holds more entries than capacity")
  `DSA_ASSERT_NEXT(a_alloc_pops,
                   state_q == S_IDLE && in_valid_i && cmd_i == CMD_ALLOC &&
                   stack_cnt_q != '0 && !cfg_we_i,
                   (stack_cnt_q + 1'b1) == $past(stack_cnt_q),
                   "alloc did not pop exactly one entry")
  `DSA_ASSERT_IMPL(a_div_done_in_div, div_done, state_q == S_DIV,
                   "divider finished outside the free sequence")

endmodule

[tb/descriptor_slot_allocator_top_test.sv]
// testbench for the descriptor slot allocator: random and directed commands checked by a predictor
`timescale 1ns / 1ps

module descriptor_slot_allocator_top_test;
  import dsa_pkg::*;

  localparam int SLOTS      = 1024;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    status_e     status;
    logic [9:0]  slot;
    logic [47:0] cpu;
    logic [47:0] gpu;
  } grant_t;

  class slot_scoreboard;
    int unsigned capacity;
    int unsigned stride;
    logic [47:0] cpu_base;
    logic [47:0] gpu_base;
    int unsigned free_slots[SLOTS];
    int unsigned depth;
    grant_t      grants_due[$];
    int          errors;
    int          checked;

    function void refill();
      for (int i = 0; i < SLOTS; i++) free_slots[i] = 0;
      for (int i = 0; i < capacity; i++) free_slots[i] = capacity - 1 - i;
      depth = capacity;
    endfunction

    function void clear();
      capacity = 0;
      stride = 0;
      cpu_base = '0;
      gpu_base = '0;
      refill();
    endfunction

    function void set_reg(cfg_reg_e idx, logic [47:0] v);
      case (idx)
        REG_CAPACITY: begin
          capacity = (v[10:0] > SLOTS) ? SLOTS : v[10:0];
          refill();
        end
        REG_STRIDE:   stride = v[12:0];
        REG_CPU_BASE: cpu_base = v;
        REG_GPU_BASE: gpu_base = v;
        default: ;
      endcase
    endfunction

    function grant_t make(status_e st, int unsigned slot, bit grant);
      grant_t g;
      longint unsigned off;
      off = longint'(slot) * stride;
      g.status = st;
      g.slot = slot[9:0];
      g.cpu = grant ? (cpu_base + off[47:0]) & MASK48 : '0;
      g.gpu = grant ? (gpu_base + off[47:0]) & MASK48 : '0;
      return g;
    endfunction

    function grant_t reserve_run(int unsigned n);
      int unsigned occ[SLOTS];
      int unsigned run_start, run_len, w;
      bit done;
      run_start = 0;
      run_len = 0;
      done = 0;
      if (n == 0 || n > capacity || n > depth) return make(ST_NO_SPACE, 0, 0);
      for (int v = 0; v < SLOTS; v++) occ[v] = 0;
      for (int i = 0; i < depth; i++) occ[free_slots[i]]++;
      for (int v = 0; v < SLOTS && !done; v++) begin
        for (int k = 0; k < occ[v] && !done; k++) begin
          if (run_len != 0 && v == run_start + run_len) begin
            run_len++;
          end else begin
            run_start = v;
            run_len = 1;
          end
          if (run_len == n) done = 1;
        end
      end
      if (run_len < n) return make(ST_NO_SPACE, 0, 0);
      w = 0;
      for (int i = 0; i < depth; i++) begin
        if (free_slots[i] >= run_start && free_slots[i] < run_start + n) continue;
        free_slots[w++] = free_slots[i];
      end
      for (int i = w; i < SLOTS; i++) free_slots[i] = 0;
      depth = w;
      return make(ST_OK, run_start, 1);
    endfunction

    function grant_t free_handle(logic [47:0] h);
      longint unsigned slot;
      if (capacity == 0 || stride == 0 || h < cpu_base) return make(ST_REJECT, 0, 0);
      slot = (longint'(h) - longint'(cpu_base)) / stride;
      if (slot >= capacity) return make(ST_REJECT, 0, 0);
      if (depth >= capacity) return make(ST_FULL, 32'(slot), 0);
      free_slots[depth++] = 32'(slot);
      return make(ST_OK, 32'(slot), 0);
    endfunction

    function void note_word(logic [1:0] cmd, logic [10:0] n, logic [47:0] h);
      grant_t g;
      case (cmd_e'(cmd))
        CMD_ALLOC: begin
          if (depth == 0) begin
            g = make(ST_NO_SPACE, 0, 0);
          end else begin
            depth--;
            g = make(ST_OK, free_slots[depth], 1);
            free_slots[depth] = 0;
          end
        end
        CMD_RESERVE: g = reserve_run(n);
        CMD_FREE:    g = free_handle(h);
        default:     g = make(ST_OK, 0, 0);
      endcase
      grants_due = {grants_due, g};
    endfunction

    function void check_word(logic [1:0] st, logic [9:0] slot, logic [47:0] cpu,
                             logic [47:0] gpu);
      grant_t g;
      checked++;
      if (grants_due.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      g = grants_due.pop_front();
      if (st !== g.status) begin
        $error("status: expected %0d actual %0d", g.status, st);
        errors++;
      end
      if (slot !== g.slot) begin
        $error("slot_index: expected %0d actual %0d", g.slot, slot);
        errors++;
      end
      if (cpu !== g.cpu) begin
        $error("cpu_address: expected %h actual %h", g.cpu, cpu);
        errors++;
      end
      if (gpu !== g.gpu) begin
        $error("gpu_address: expected %h actual %h", g.gpu, gpu);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  cmd_i;
  logic [10:0] count_i;
  logic [47:0] cpu_handle_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [9:0]  slot_index_o;
  logic [47:0] cpu_address_o;
  logic [47:0] gpu_address_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [47:0] cfg_wdata_i;

  slot_scoreboard sb;
  int  stall_pct;
  bit  hold_req;
  int  words_sent;

  descriptor_slot_allocator_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .cmd_i(cmd_i), .count_i(count_i), .cpu_handle_i(cpu_handle_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .status_o(status_o), .slot_index_o(slot_index_o),
    .cpu_address_o(cpu_address_o), .gpu_address_o(gpu_address_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word(status_o, slot_index_o, cpu_address_o, gpu_address_o);
  end

  // receiver stalls, with one long hold-off on request
  initial begin
    out_stall_i = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_stall_i <= 1;
        repeat (800) @(posedge clk_i);
        out_stall_i <= 0;
      end else if ($urandom_range(0, 99) == 0) begin
        out_stall_i <= 1;
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
        out_stall_i <= 0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // watchdog on cycles with no word moving
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_word(logic [1:0] cmd, logic [10:0] n, logic [47:0] h);
    int r, gap;
    cmd_i <= cmd;
    count_i <= n;
    cpu_handle_i <= h;
    in_valid_i <= 1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_word(cmd, n, h);
    words_sent++;
    r = $urandom_range(0, 9);
    gap = (r < 5) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.grants_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [47:0] v);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic configure(logic [47:0] cap, logic [47:0] strd, logic [47:0] cb,
                           logic [47:0] gb);
    drain();
    write_reg(REG_STRIDE, strd);
    write_reg(REG_CPU_BASE, cb);
    write_reg(REG_GPU_BASE, gb);
    write_reg(REG_CAPACITY, cap);
    @(posedge clk_i);
  endtask

  function automatic logic [47:0] handle_of(int unsigned slot, int unsigned off);
    longint unsigned a;
    a = longint'(slot) * sb.stride + off;
    return (sb.cpu_base + a[47:0]) & MASK48;
  endfunction

  task automatic send_random(int num);
    int r, c;
    logic [10:0] n;
    logic [47:0] h;
    for (int i = 0; i < num; i++) begin
      r = $urandom_range(0, 99);
      n = 11'($urandom_range(0, 2047));
      h = 48'({$urandom, $urandom});
      if (r < 30) begin
        send_word(CMD_ALLOC, n, h);
      end else if (r < 45) begin
        c = $urandom_range(0, 9);
        if (c < 8) n = 11'($urandom_range(1, 6));
        else if (c < 9) n = 11'($urandom_range(1, (sb.capacity > 0) ? sb.capacity : 1));
        send_word(CMD_RESERVE, n, h);
      end else if (r < 92) begin
        if (r < 85)
          h = handle_of($urandom_range(0, sb.capacity + 1),
                        (sb.stride > 0) ? $urandom_range(0, sb.stride - 1) : 0);
        send_word(CMD_FREE, n, h);
      end else begin
        send_word(CMD_NONE, n, h);
      end
    end
  endtask

  initial begin
    sb = new;
    sb.clear();
    rst_ni = 0;
    in_valid_i = 0;
    cmd_i = '0;
    count_i = '0;
    cpu_handle_i = '0;
    cfg_we_i = 0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    stall_pct = 0;
    hold_req = 0;
    words_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // inactive heap after reset
    send_word(CMD_ALLOC, 0, 0);
    send_word(CMD_RESERVE, 1, 0);
    send_word(CMD_FREE, 0, 0);
    send_word(CMD_NONE, 11'h7FF, MASK48);

    configure(8, 1, 48'h100, MASK48);
    send_word(CMD_FREE, 0, 48'h103);
    send_word(CMD_ALLOC, 0, 0);
    send_word(CMD_ALLOC, 0, 0);
    send_word(CMD_ALLOC, 0, 0);
    send_word(CMD_RESERVE, 0, 0);
    send_word(CMD_RESERVE, 11'h7FF, 0);
    send_word(CMD_RESERVE, 9, 0);
    send_word(CMD_RESERVE, 6, 0);
    send_word(CMD_RESERVE, 2, 0);
    send_word(CMD_FREE, 0, 48'hFF);
    send_word(CMD_FREE, 0, 48'h108);
    send_word(CMD_FREE, 0, 48'h100);
    send_word(CMD_FREE, 0, 48'h100);
    send_word(CMD_FREE, 0, 48'h101);
    send_word(CMD_RESERVE, 1, 0);
    send_word(CMD_RESERVE, 3, 0);
    for (int i = 0; i < 6; i++) send_word(CMD_ALLOC, 0, 0);
    stall_pct = 30;
    send_random(55);

    // saturated capacity, widest stride, high bases
    configure(2047, 8191, 48'hFFFF_FF80_0000, MASK48);
    stall_pct = 10;
    hold_req = 1;
    send_random(60);

    configure(1, 0, 0, 0);
    stall_pct = 70;
    send_random(25);

    configure(0, 4, 48'h1000, 48'h2000);
    stall_pct = 0;
    send_random(15);

    configure(48'($urandom_range(2, 64)), 48'($urandom_range(1, 64)),
              48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
    stall_pct = 40;
    send_random(110);

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.grants_due.size() != 0) begin
      $error("%0d result words never arrived", sb.grants_due.size());
      sb.errors++;
    end
    $display("sent %0d command words over five heap settings, checked %0d results",
             words_sent, sb.checked);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
